### hw/rtl/pcoie_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the protocol configuration options element parser.
// Used by the front classifier, the item queue, the back parser and the top level.
package pcoie_pkg;

  // Container limit and the widths that follow from it.
  localparam int MaxContainers = 32;
  localparam int CountW        = $clog2(MaxContainers + 1);
  localparam int IdxW          = 6;

  // Queue between the front and the back.
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  // Header octet: bit 7 set, spare bits 6..3 clear.
  localparam logic [7:0] HdrSpareMask = 8'h78;

  // Output stream tdata width, padded to whole bytes.
  localparam int OutDataW = 48;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_LEN  = 3'd1,
    PH_HDR  = 3'd2,
    PH_CHI  = 3'd3,
    PH_CLO  = 3'd4,
    PH_CLEN = 3'd5,
    PH_DATA = 3'd6,
    PH_LEFT = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KIND_OVERHEAD = 2'd0,
    KIND_CONTENT  = 2'd1,
    KIND_HEADER   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_HEADER   = 3'd1,
    ERR_SHORT    = 3'd2,
    ERR_OVERRUN  = 3'd3,
    ERR_LEFTOVER = 3'd4,
    ERR_TOO_MANY = 3'd5
  } err_e;

  // One classified input beat as it travels through the queue.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       typed;
    logic       last;
    logic       hdr_ok;
    logic [2:0] proto;
  } item_t;

endpackage

### hw/rtl/pco_ie_tlv_parser.sv
`timescale 1ns / 1ps
// Protocol configuration options element parser, top level.
// Each accepted input beat passes the queue and then the output register.
// Throughput: one byte (one queued beat) per cycle unless the output side stalls.
// A four-entry queue lets the input side keep going while the output side stalls.
// Reset (rst_ni low, asynchronous) empties the queue and returns the parser to idle.
module pco_ie_tlv_parser import pcoie_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,  // [7:0] data_byte
  input  logic [1:0]          s_axis_tuser_i,  // [0] first, [1] has_type_byte
  input  logic                s_axis_tlast_i,  // last
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [7:0] content_byte, [23:8] container_id, [31:24] container_length,
  // [37:32] container_index, [40:38] protocol, [43:41] error_code, [47:44] zero
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic [1:0]          m_axis_tuser_o,  // [1:0] kind
  output logic                m_axis_tlast_o   // element_done
);

  logic  q_full;
  logic  q_push;
  item_t q_in;
  logic  q_pop;
  logic  q_empty;
  item_t q_out;

  // Input classification.
  pcoie_front u_front (
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .data_i     (s_axis_tdata_i),
    .first_i    (s_axis_tuser_i[0]),
    .typed_i    (s_axis_tuser_i[1]),
    .last_i     (s_axis_tlast_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_in)
  );

  // Decoupling queue.
  pcoie_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_out)
  );

  // Element parser and output register.
  pcoie_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_item_i    (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .kind_o      (m_axis_tuser_o),
    .done_o      (m_axis_tlast_o),
    .data_o      (m_axis_tdata_o)
  );

endmodule

### hw/rtl/pcoie_front.sv
`timescale 1ns / 1ps
// Front end of the parser: takes input beats and classifies them.
// Depends on pcoie_pkg for the item type and header mask.
module pcoie_front import pcoie_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_i,
  input  logic       first_i,
  input  logic       typed_i,
  input  logic       last_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output item_t      q_item_o
);

  // A beat is taken whenever the queue has room.
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Pre-decode the header octet checks so the back only selects.
  always_comb begin
    q_item_o.data   = data_i;
    q_item_o.first  = first_i;
    q_item_o.typed  = typed_i;
    q_item_o.last   = last_i;
    q_item_o.hdr_ok = data_i[7] && ((data_i & HdrSpareMask) == 8'h00);
    q_item_o.proto  = data_i[3:1];
  end

endmodule

### hw/rtl/pcoie_queue.sv
`timescale 1ns / 1ps
// Short queue of classified beats between the front and the back.
// Depends on pcoie_pkg for the item type and depth.
module pcoie_queue import pcoie_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t item_o
);

  item_t           mem_q [QDepth];
  logic [QAw-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QAw-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QAw:0]    count_q, count_d;

  assign full_o  = (count_q == (QAw+1)'(QDepth));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### hw/rtl/pcoie_back.sv
`timescale 1ns / 1ps
// Back end of the parser: walks the element state machine and registers results.
// Depends on pcoie_pkg for the phase, kind and error codes and the item type.
module pcoie_back import pcoie_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  item_t               q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          kind_o,
  output logic                done_o,
  output logic [OutDataW-1:0] data_o
);

  phase_e            phase_q, phase_d;
  logic [15:0]       elem_len_q, elem_len_d;
  logic [15:0]       left_q, left_d;
  logic              pending_q, pending_d;
  logic [15:0]       id_q, id_d;
  logic [7:0]        clen_q, clen_d;
  logic [7:0]        content_q, content_d;
  logic [CountW-1:0] count_q, count_d;
  logic [2:0]        proto_q, proto_d;

  logic              fin;
  err_e              err;
  kind_e             kind;
  logic [7:0]        cbyte;
  logic [15:0]       left_dec;
  logic [15:0]       len_full;
  logic [CountW-1:0] idx_full;

  logic              out_valid_q;
  kind_e             kind_q;
  logic              done_q;
  logic [OutDataW-1:0] data_q;

  // Advance when a beat waits and the output register is free or draining.
  assign q_pop_o  = !q_empty_i && (!out_valid_q || out_ready_i);
  assign left_dec = left_q - 16'd1;
  assign len_full = {elem_len_q[15:8], q_item_i.data};

  // Next state and result for the beat at the head of the queue.
  always_comb begin
    phase_d    = phase_q;
    elem_len_d = elem_len_q;
    left_d     = left_q;
    pending_d  = pending_q;
    id_d       = id_q;
    clen_d     = clen_q;
    content_d  = content_q;
    count_d    = count_q;
    proto_d    = proto_q;
    fin        = 1'b0;
    err        = ERR_OK;
    kind       = KIND_OVERHEAD;
    cbyte      = 8'h00;

    if (q_item_i.first) begin
      // A new element always restarts, dropping any open one.
      phase_d    = PH_LEN;
      elem_len_d = q_item_i.typed ? 16'h0000 : {q_item_i.data, 8'h00};
      pending_d  = !q_item_i.typed;
      left_d     = '0;
      id_d       = '0;
      clen_d     = '0;
      content_d  = '0;
      count_d    = '0;
      proto_d    = '0;
    end else begin
      case (phase_q)
        PH_LEN: begin
          if (!pending_q) begin
            elem_len_d = {q_item_i.data, 8'h00};
            pending_d  = 1'b1;
          end else begin
            elem_len_d = len_full;
            pending_d  = 1'b0;
            if (len_full == 16'h0000) begin
              fin = 1'b1;
              err = ERR_LEFTOVER;
            end else begin
              phase_d = PH_HDR;
            end
          end
        end
        PH_HDR: begin
          if (!q_item_i.hdr_ok) begin
            fin = 1'b1;
            err = ERR_HEADER;
          end else begin
            proto_d = q_item_i.proto;
            left_d  = elem_len_q - 16'd1;
          end
        end
        PH_CHI: begin
          left_d = left_dec;
          if (count_q >= CountW'(MaxContainers)) begin
            fin = 1'b1;
            err = ERR_TOO_MANY;
          end else begin
            count_d = count_q + 1'b1;
            id_d    = {q_item_i.data, 8'h00};
            clen_d  = '0;
            phase_d = PH_CLO;
          end
        end
        PH_CLO: begin
          left_d  = left_dec;
          id_d    = {id_q[15:8], q_item_i.data};
          phase_d = PH_CLEN;
        end
        PH_CLEN: begin
          left_d = left_dec;
          clen_d = q_item_i.data;
          kind   = KIND_HEADER;
          if ({8'h00, q_item_i.data} > left_dec) begin
            fin = 1'b1;
            err = ERR_OVERRUN;
          end else begin
            content_d = q_item_i.data;
            if (q_item_i.data != 8'h00) begin
              phase_d = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          left_d    = left_dec;
          content_d = content_q - 8'd1;
          kind      = KIND_CONTENT;
          cbyte     = q_item_i.data;
        end
        PH_LEFT: begin
          left_d = left_dec;
          if (left_dec == 16'h0000) begin
            fin = 1'b1;
            err = ERR_LEFTOVER;
          end
        end
        default: begin
        end
      endcase

      // Container boundary: after the header octet, an empty container or
      // the last content byte, decide what the remaining bytes hold.
      if (!fin && ((phase_q == PH_HDR) ||
                   (phase_q == PH_CLEN && q_item_i.data == 8'h00) ||
                   (phase_q == PH_DATA && content_q == 8'd1))) begin
        if (left_d == 16'h0000) begin
          fin = 1'b1;
          err = ERR_OK;
        end else if (left_d < 16'd3) begin
          phase_d = PH_LEFT;
        end else begin
          phase_d = PH_CHI;
        end
      end
    end

    if (fin) begin
      phase_d = PH_IDLE;
    end

    // The buffer ran out while the element is still open.
    if (!fin && phase_d != PH_IDLE && q_item_i.last) begin
      fin     = 1'b1;
      err     = ERR_SHORT;
      phase_d = PH_IDLE;
    end
  end

  assign idx_full = (count_d != '0) ? count_d - 1'b1 : '0;

  // Parser state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      elem_len_q <= '0;
      left_q     <= '0;
      pending_q  <= 1'b0;
      id_q       <= '0;
      clen_q     <= '0;
      content_q  <= '0;
      count_q    <= '0;
      proto_q    <= '0;
    end else if (q_pop_o) begin
      phase_q    <= phase_d;
      elem_len_q <= elem_len_d;
      left_q     <= left_d;
      pending_q  <= pending_d;
      id_q       <= id_d;
      clen_q     <= clen_d;
      content_q  <= content_d;
      count_q    <= count_d;
      proto_q    <= proto_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload, loaded with each result beat.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      kind_q <= kind;
      done_q <= fin;
      data_q <= {4'h0, err, proto_d, IdxW'(idx_full), clen_d, id_d, cbyte};
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign done_o      = done_q;
  assign data_o      = data_q;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the protocol configuration options element parser.
// Depends on pcoie_pkg and pco_ie_tlv_parser; a behavioral parser model predicts every beat.
module tb;
  import pcoie_pkg::*;

  // One predicted or observed result beat.
  typedef struct packed {
    kind_e            kind;
    logic [7:0]       content;
    logic [15:0]      id;
    logic [7:0]       length;
    logic [IdxW-1:0]  index;
    logic [2:0]       proto;
    logic             done;
    err_e             err;
  } parse_res_t;

  // One input beat; when fixed is set, kind, done and err are known by hand.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       typed;
    logic       last;
    logic       fixed;
    kind_e      kind;
    logic       done;
    err_e       err;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i = '0;  // [7:0] data_byte
  logic [1:0]          s_axis_tuser_i = '0;  // [0] first, [1] has_type_byte
  logic                s_axis_tlast_i = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [1:0]          m_axis_tuser_o;
  logic                m_axis_tlast_o;

  // Parser state as the model tracks it.
  phase_e      p_phase = PH_IDLE;
  logic [15:0] p_elem_len = '0;
  logic [15:0] p_left = '0;
  logic        p_lo_pending = 1'b0;
  logic [15:0] p_id = '0;
  logic [7:0]  p_clen = '0;
  logic [7:0]  p_cleft = '0;
  int unsigned p_count = 0;
  logic [2:0]  p_proto = '0;

  parse_res_t predicted_beats[$];
  int mismatches = 0;
  int element_beats = 0;
  int send_idle_pct = 38;
  int recv_idle_pct = 85;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;

  // Directed beats: idle byte after reset, a full element ending in two leftover
  // bytes, a bad header octet, a zero length, a content overrun and a short buffer.
  stim_row_t directed_rows [0:24] = '{
    '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b1, KIND_OVERHEAD, 1'b0, ERR_OK},
    '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, KIND_OVERHEAD, 1'b0, ERR_OK},
    '{8'h09, 1'b0, 1'b0, 1'b0, 1'b0, KIND_OVERHEAD, 1'b0, ERR_OK},
    '{8'h87, 1'b0, 1'b0, 1'b0, 1'b0, KIND_OVERHEAD, 1'b0, ERR_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, KIND_OVERHEAD, 1'b0, ERR_OK},
    '{8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, KIND_OVERHEAD, 1'b0, ERR_OK},
    '{8'h03, 1'b0, 1'b0, 1'b0, 1'b0, KIND_OVERHEAD, 1'b0, ERR_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, KIND_OVERHEAD, 1'b0, ERR_OK},
    '{8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, KIND_OVERHEAD, 1'b0, ERR_OK},
    '{8'hA5, 1'b0, 1'b0, 1'b0, 1'b0, KIND_OVERHEAD, 1'b0, ERR_OK},
    '{8'h12, 1'b0, 1'b0, 1'b0, 1'b0, KIND_OVERHEAD, 1'b0, ERR_OK},
    '{8'h34, 1'b0, 1'b0, 1'b0, 1'b1, KIND_OVERHEAD, 1'b1, ERR_LEFTOVER},
    '{8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, KIND_OVERHEAD, 1'b0, ERR_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, KIND_OVERHEAD, 1'b0, ERR_OK},
    '{8'h05, 1'b0, 1'b0, 1'b0, 1'b0, KIND_OVERHEAD, 1'b0, ERR_OK},
    '{8'h78, 1'b0, 1'b0, 1'b0, 1'b1, KIND_OVERHEAD, 1'b1, ERR_HEADER},
    '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, KIND_OVERHEAD, 1'b0, ERR_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, KIND_OVERHEAD, 1'b1, ERR_LEFTOVER},
    '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, KIND_OVERHEAD, 1'b0, ERR_OK},
    '{8'h04, 1'b0, 1'b0, 1'b0, 1'b0, KIND_OVERHEAD, 1'b0, ERR_OK},
    '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0, KIND_OVERHEAD, 1'b0, ERR_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, KIND_OVERHEAD, 1'b0, ERR_OK},
    '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0, KIND_OVERHEAD, 1'b0, ERR_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b1, KIND_HEADER,   1'b1, ERR_OVERRUN},
    '{8'hA5, 1'b1, 1'b1, 1'b1, 1'b1, KIND_OVERHEAD, 1'b1, ERR_SHORT}
  };

  pco_ie_tlv_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // 125 MHz clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // A generous fixed limit on the whole run.
  initial begin
    #5ms;
    $display("tb: errors");
    $finish;
  end

  // At a container boundary, either the element ends cleanly or the next part starts.
  function automatic logic close_container();
    if (p_left == 16'd0) begin
      p_phase = PH_IDLE;
      return 1'b1;
    end
    p_phase = (p_left < 16'd3) ? PH_LEFT : PH_CHI;
    return 1'b0;
  endfunction

  // Advance the parser model by one byte and return the beat it should emit.
  function automatic parse_res_t parse_byte(input logic [7:0] b, input logic f, input logic t,
                                            input logic l);
    parse_res_t r;
    logic       fin;
    err_e       code;
    r = '0;
    fin = 1'b0;
    code = ERR_OK;
    if (f) begin
      p_phase = PH_LEN;
      p_elem_len = '0;
      p_left = '0;
      p_lo_pending = 1'b0;
      p_id = '0;
      p_clen = '0;
      p_cleft = '0;
      p_count = 0;
      p_proto = '0;
      if (!t) begin
        p_elem_len = {b, 8'h00};
        p_lo_pending = 1'b1;
      end
    end else begin
      case (p_phase)
        PH_LEN: begin
          if (!p_lo_pending) begin
            p_elem_len = {b, 8'h00};
            p_lo_pending = 1'b1;
          end else begin
            p_elem_len = p_elem_len | {8'h00, b};
            p_lo_pending = 1'b0;
            if (p_elem_len == 16'd0) begin
              fin = 1'b1;
              code = ERR_LEFTOVER;
            end else begin
              p_phase = PH_HDR;
            end
          end
        end
        PH_HDR: begin
          if (!b[7] || (b & HdrSpareMask) != 8'h00) begin
            fin = 1'b1;
            code = ERR_HEADER;
          end else begin
            p_proto = b[3:1];
            p_left = p_elem_len - 16'd1;
            fin = close_container();
          end
        end
        PH_CHI: begin
          p_left = p_left - 16'd1;
          if (p_count >= MaxContainers) begin
            fin = 1'b1;
            code = ERR_TOO_MANY;
          end else begin
            p_count++;
            p_id = {b, 8'h00};
            p_clen = '0;
            p_phase = PH_CLO;
          end
        end
        PH_CLO: begin
          p_left = p_left - 16'd1;
          p_id = p_id | {8'h00, b};
          p_phase = PH_CLEN;
        end
        PH_CLEN: begin
          p_left = p_left - 16'd1;
          p_clen = b;
          r.kind = KIND_HEADER;
          if ({8'h00, b} > p_left) begin
            fin = 1'b1;
            code = ERR_OVERRUN;
          end else begin
            p_cleft = b;
            if (b == 8'h00) fin = close_container();
            else p_phase = PH_DATA;
          end
        end
        PH_DATA: begin
          p_left = p_left - 16'd1;
          p_cleft = p_cleft - 8'd1;
          r.kind = KIND_CONTENT;
          r.content = b;
          if (p_cleft == 8'h00) fin = close_container();
        end
        PH_LEFT: begin
          p_left = p_left - 16'd1;
          if (p_left == 16'd0) begin
            fin = 1'b1;
            code = ERR_LEFTOVER;
          end
        end
        default: ;
      endcase
    end
    // The buffer running out only matters while an element is still open.
    if (fin) begin
      p_phase = PH_IDLE;
    end else if (p_phase != PH_IDLE && l) begin
      fin = 1'b1;
      code = ERR_SHORT;
      p_phase = PH_IDLE;
    end
    r.id = p_id;
    r.length = p_clen;
    r.index = (p_count != 0) ? IdxW'(p_count - 1) : '0;
    r.proto = p_proto;
    r.done = fin;
    r.err = code;
    return r;
  endfunction

  function automatic stim_row_t make_beat(input logic [7:0] b, input logic f, input logic t,
                                          input logic l);
    stim_row_t row;
    row = '0;
    row.data = b;
    row.first = f;
    row.typed = t;
    row.last = l;
    return row;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Offer one beat, with random idle cycles ahead of it, and predict its result.
  task automatic drive_byte(input stim_row_t row);
    parse_res_t pred;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= row.data;
    s_axis_tuser_i <= {row.typed, row.first};
    s_axis_tlast_i <= row.last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pred = parse_byte(row.data, row.first, row.typed, row.last);
    if (row.fixed) begin
      pred.kind = row.kind;
      pred.done = row.done;
      pred.err = row.err;
    end
    predicted_beats.push_back(pred);
  endtask

  task automatic idle_bus();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (predicted_beats.size() != 0) @(posedge clk_i);
  endtask

  // Build one element with random content; most are well formed, some carry a bad
  // header, a wrong length, leftover bytes, too many containers or an early end.
  task automatic send_element();
    logic [7:0]  body[$];
    logic [7:0]  stream[$];
    logic        typed;
    logic [15:0] len_field;
    bit          many;
    int          n_cont;
    int          c_len;
    int          flaw;
    int          stop_at;
    int          last_at;
    typed = 1'($urandom_range(1));
    if ($urandom_range(15) == 0) body.push_back(8'($urandom));
    else body.push_back({1'b1, 4'b0000, 3'($urandom)});
    many = ($urandom_range(19) == 0);
    n_cont = many ? $urandom_range(30, 34) : $urandom_range(0, 4);
    repeat (n_cont) begin
      if (many) c_len = $urandom_range(0, 1);
      else if ($urandom_range(9) == 0) c_len = $urandom_range(20, 60);
      else c_len = $urandom_range(0, 6);
      body.push_back(8'($urandom));
      body.push_back(8'($urandom));
      body.push_back(8'(c_len));
      repeat (c_len) body.push_back(8'($urandom));
    end
    flaw = $urandom_range(11);
    if (flaw == 0) repeat ($urandom_range(1, 2)) body.push_back(8'($urandom));
    len_field = 16'(body.size());
    case (flaw)
      1: len_field = len_field - 16'($urandom_range(1, 3));
      2: len_field = len_field + 16'($urandom_range(1, 5));
      3: len_field = '0;
      default: ;
    endcase
    if (typed) stream.push_back(8'($urandom));
    stream.push_back(len_field[15:8]);
    stream.push_back(len_field[7:0]);
    foreach (body[i]) stream.push_back(body[i]);
    // Usually the buffer ends on the last byte; sometimes early, sometimes a restart.
    last_at = stream.size() - 1;
    stop_at = last_at;
    case ($urandom_range(9))
      0: begin
        stop_at = $urandom_range(0, last_at);
        last_at = stop_at;
      end
      1: begin
        stop_at = $urandom_range(0, last_at);
        last_at = -1;
      end
      default: ;
    endcase
    for (int i = 0; i <= stop_at; i++) begin
      drive_byte(make_beat(stream[i], i == 0, (i == 0) ? typed : 1'($urandom), i == last_at));
      element_beats++;
    end
  endtask

  // Receiver: random back-pressure, plus long hold-offs on request.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = 300;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare every accepted result beat with the oldest prediction.
  always @(posedge clk_i) begin
    parse_res_t got;
    parse_res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind = kind_e'(m_axis_tuser_o);
      got.content = m_axis_tdata_o[7:0];
      got.id = m_axis_tdata_o[23:8];
      got.length = m_axis_tdata_o[31:24];
      got.index = m_axis_tdata_o[37:32];
      got.proto = m_axis_tdata_o[40:38];
      got.done = m_axis_tlast_o;
      got.err = err_e'(m_axis_tdata_o[43:41]);
      if (predicted_beats.size() == 0) begin
        $error("result beat with no prediction pending");
        mismatches++;
      end else begin
        want = predicted_beats.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("content_byte", want.content, got.content);
        check_field("container_id", want.id, got.id);
        check_field("container_length", want.length, got.length);
        check_field("container_index", want.index, got.index);
        check_field("protocol", want.proto, got.proto);
        check_field("element_done", want.done, got.done);
        check_field("error_code", want.err, got.err);
      end
    end
  end

  // Main sequence: reset, directed beats, then three random stages.
  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed_rows[i]) drive_byte(directed_rows[i]);
    idle_bus();
    wait_drained();
    for (int stage = 0; stage < 3; stage++) begin
      case (stage)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 85;
        end
        1: begin
          send_idle_pct = 85;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // Long receiver stall while the sender keeps pushing.
          hold_requests++;
        end
      endcase
      while (element_beats < (stage + 1) * 500) begin
        if ($urandom_range(5) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            drive_byte(make_beat(8'($urandom), 1'b0, 1'($urandom), 1'($urandom)));
          end
        end
        send_element();
      end
      // Sender pauses until every predicted beat has arrived.
      idle_bus();
      wait_drained();
    end
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
